// ===== rtl/core/ihdk_pkg.sv =====
package ihdk_pkg;

    // operation codes on the mode field
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_PUSH   = 2'd0;
    localparam t_mode MODE_POP    = 2'd1;
    localparam t_mode MODE_CHANGE = 2'd2;

    // result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_EMPTY   = 3'd1;
    localparam t_status ST_FULL    = 3'd2;
    localparam t_status ST_ABSENT  = 3'd3;
    localparam t_status ST_DUP     = 3'd4;

    // label space is fixed by the label field
    localparam int LABEL_BITS = 8;
    localparam int LABELS     = 256;
    typedef logic [LABEL_BITS-1:0] t_label;

endpackage

// ===== rtl/core/indexed_min_heap_decrease_key_core.sv =====
// channel  | direction | transfer when       | signals
// command  | in        | i_start && !o_busy  | i_mode, i_key, i_label
// result   | out       | o_done (one cycle)  | o_out_label, o_out_key, o_status, o_count
//
// one command at a time; each sift level takes one slot read going up and one or two going
// down, all through the single read port of the slot memory, whose read data is registered
// reset clears the count and the label present bits at once, no clearing pass
// o_busy drops in the cycle o_done is shown; the receiver cannot stall results
module indexed_min_heap_decrease_key_core #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  ihdk_pkg::t_mode          i_mode,
    input  logic signed [31:0]       i_key,
    input  logic [7:0]               i_label,
    output logic                     o_done,
    output logic [7:0]               o_out_label,
    output logic signed [31:0]       o_out_key,
    output ihdk_pkg::t_status        o_status,
    output logic [8:0]               o_count
);
    import ihdk_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = SW + 2;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP       = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_POP_TOP  = 4'd3;
    localparam logic [3:0] S_POP_LAST = 4'd4;
    localparam logic [3:0] S_DN       = 4'd5;
    localparam logic [3:0] S_DN_L     = 4'd6;
    localparam logic [3:0] S_DN_R     = 4'd7;
    localparam logic [3:0] S_DN_CMP   = 4'd8;
    localparam logic [3:0] S_CH_POS   = 4'd9;
    localparam logic [3:0] S_CH_RD    = 4'd10;
    localparam logic [3:0] S_FIN      = 4'd11;

    // slot memories and label to slot map
    logic signed [KEY_BITS-1:0] mem_key [CAPACITY];
    t_label                     mem_lab [CAPACITY];
    logic [SW-1:0]              mem_pos [LABELS];

    logic [3:0]                 r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [LABELS-1:0]          r_present, n_present;
    logic                       r_done, n_done;
    logic                       r_wb, n_wb;
    logic [SW-1:0]              r_idx, n_idx;
    logic signed [KEY_BITS-1:0] r_cur_key, n_cur_key;
    t_label                     r_cur_lab, n_cur_lab;
    logic [EW-1:0]              r_cidx, n_cidx;
    logic signed [KEY_BITS-1:0] r_c_key, n_c_key;
    t_label                     r_c_lab, n_c_lab;
    t_label                     r_olab, n_olab;
    logic signed [KEY_BITS-1:0] r_okey, n_okey;
    t_status                    r_status, n_status;

    // memory read data, registered
    logic signed [KEY_BITS-1:0] r_rd_key;
    t_label                     r_rd_lab;
    logic [SW-1:0]              r_rd_pos;

    logic                       w_hrd_en, w_hwr_en, w_prd_en, w_pwr_en;
    logic [SW-1:0]              w_hrd_addr, w_hwr_addr, w_pwr_data;
    logic signed [KEY_BITS-1:0] w_hwr_key;
    t_label                     w_hwr_lab, w_prd_addr, w_pwr_addr;

    logic signed [KEY_BITS-1:0] w_in_key;
    logic [EW-1:0]              w_left, w_right, w_count_e;
    logic [SW-1:0]              w_parent;
    logic [CW-1:0]              w_count_m1;

    assign w_in_key   = KEY_BITS'(i_key);
    assign w_left     = {1'b0, r_idx, 1'b1};
    assign w_right    = w_left + EW'(1);
    assign w_count_e  = EW'(r_count);
    assign w_parent   = SW'((r_idx - SW'(1)) >> 1);
    assign w_count_m1 = r_count - CW'(1);

    // sequencer: read, compare, move the displaced entry, track the hole
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_present = r_present;
        n_done    = 1'b0;
        n_wb      = r_wb;
        n_idx     = r_idx;
        n_cur_key = r_cur_key;
        n_cur_lab = r_cur_lab;
        n_cidx    = r_cidx;
        n_c_key   = r_c_key;
        n_c_lab   = r_c_lab;
        n_olab    = r_olab;
        n_okey    = r_okey;
        n_status  = r_status;
        w_hrd_en   = 1'b0;
        w_hrd_addr = '0;
        w_hwr_en   = 1'b0;
        w_hwr_addr = r_idx;
        w_hwr_key  = r_cur_key;
        w_hwr_lab  = r_cur_lab;
        w_prd_en   = 1'b0;
        w_prd_addr = i_label;
        w_pwr_en   = 1'b0;
        w_pwr_addr = r_cur_lab;
        w_pwr_data = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_olab    = '0;
                    n_okey    = '0;
                    n_status  = ST_OK;
                    n_wb      = 1'b1;
                    n_cur_key = w_in_key;
                    n_cur_lab = i_label;
                    n_state   = S_FIN;
                    if (i_mode == MODE_PUSH) begin
                        if (r_present[i_label]) begin
                            n_status = ST_DUP;
                            n_wb     = 1'b0;
                        end else if (r_count >= CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_wb     = 1'b0;
                        end else begin
                            n_idx              = SW'(r_count);
                            n_count            = r_count + CW'(1);
                            n_present[i_label] = 1'b1;
                            n_state            = S_UP;
                        end
                    end else if (i_mode == MODE_POP) begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_wb     = 1'b0;
                        end else begin
                            w_hrd_en   = 1'b1;
                            w_hrd_addr = '0;
                            n_state    = S_POP_TOP;
                        end
                    end else if (i_mode == MODE_CHANGE) begin
                        if (!r_present[i_label]) begin
                            n_status = ST_ABSENT;
                            n_wb     = 1'b0;
                        end else begin
                            w_prd_en = 1'b1;
                            n_state  = S_CH_POS;
                        end
                    end else begin
                        n_wb = 1'b0;
                    end
                end
            end
            S_UP: begin
                if (r_idx == '0) begin
                    n_state = S_FIN;
                end else begin
                    w_hrd_en   = 1'b1;
                    w_hrd_addr = w_parent;
                    n_state    = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (r_cur_key < r_rd_key) begin
                    // parent moves down into the hole
                    w_hwr_en   = 1'b1;
                    w_hwr_key  = r_rd_key;
                    w_hwr_lab  = r_rd_lab;
                    w_pwr_en   = 1'b1;
                    w_pwr_addr = r_rd_lab;
                    n_idx      = w_parent;
                    n_state    = S_UP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POP_TOP: begin
                n_olab             = r_rd_lab;
                n_okey             = r_rd_key;
                n_present[r_rd_lab] = 1'b0;
                n_count            = w_count_m1;
                if (w_count_m1 == '0) begin
                    n_wb    = 1'b0;
                    n_state = S_FIN;
                end else begin
                    w_hrd_en   = 1'b1;
                    w_hrd_addr = SW'(w_count_m1);
                    n_state    = S_POP_LAST;
                end
            end
            S_POP_LAST: begin
                n_cur_key = r_rd_key;
                n_cur_lab = r_rd_lab;
                n_idx     = '0;
                n_state   = S_DN;
            end
            S_DN: begin
                if (w_left >= w_count_e) begin
                    n_state = S_FIN;
                end else begin
                    w_hrd_en   = 1'b1;
                    w_hrd_addr = SW'(w_left);
                    n_cidx     = w_left;
                    n_state    = S_DN_L;
                end
            end
            S_DN_L: begin
                n_c_key = r_rd_key;
                n_c_lab = r_rd_lab;
                if (w_right < w_count_e) begin
                    w_hrd_en   = 1'b1;
                    w_hrd_addr = SW'(w_right);
                    n_state    = S_DN_R;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_R: begin
                // right child only on strictly smaller key
                if (r_rd_key < r_c_key) begin
                    n_c_key = r_rd_key;
                    n_c_lab = r_rd_lab;
                    n_cidx  = w_right;
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (r_c_key < r_cur_key) begin
                    w_hwr_en   = 1'b1;
                    w_hwr_key  = r_c_key;
                    w_hwr_lab  = r_c_lab;
                    w_pwr_en   = 1'b1;
                    w_pwr_addr = r_c_lab;
                    n_idx      = SW'(r_cidx);
                    n_state    = S_DN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CH_POS: begin
                if (CW'(r_rd_pos) >= r_count) begin
                    n_status = ST_ABSENT;
                    n_wb     = 1'b0;
                    n_state  = S_FIN;
                end else begin
                    n_idx      = r_rd_pos;
                    w_hrd_en   = 1'b1;
                    w_hrd_addr = r_rd_pos;
                    n_state    = S_CH_RD;
                end
            end
            S_CH_RD: begin
                if (r_rd_key < r_cur_key) begin
                    n_state = S_DN;
                end else begin
                    n_state = S_UP;
                end
            end
            S_FIN: begin
                // moving entry lands in the hole
                w_hwr_en = r_wb;
                w_pwr_en = r_wb;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (w_hwr_en) begin
            mem_key[w_hwr_addr] <= w_hwr_key;
            mem_lab[w_hwr_addr] <= w_hwr_lab;
        end
        if (w_hrd_en) begin
            r_rd_key <= mem_key[w_hrd_addr];
            r_rd_lab <= mem_lab[w_hrd_addr];
        end
    end

    // label to slot map
    always_ff @(posedge i_clk) begin
        if (w_pwr_en) begin
            mem_pos[w_pwr_addr] <= w_pwr_data;
        end
        if (w_prd_en) begin
            r_rd_pos <= mem_pos[w_prd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_present <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_present <= n_present;
            r_done    <= n_done;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_wb      <= n_wb;
        r_idx     <= n_idx;
        r_cur_key <= n_cur_key;
        r_cur_lab <= n_cur_lab;
        r_cidx    <= n_cidx;
        r_c_key   <= n_c_key;
        r_c_lab   <= n_c_lab;
        r_olab    <= n_olab;
        r_okey    <= n_okey;
        r_status  <= n_status;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_out_label = r_olab;
    assign o_out_key   = 32'(r_okey);
    assign o_status    = r_status;
    assign o_count     = 9'(r_count);

endmodule

// ===== tb/indexed_min_heap_decrease_key_core_test.sv =====
`timescale 1ns / 1ps

module indexed_min_heap_decrease_key_core_test;
    import ihdk_pkg::*;

    localparam int HEAP_CAP = 256;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        t_mode             mode;
        logic signed [31:0] key;
        t_label            label;
    } t_cmd;

    typedef struct packed {
        t_label             label;
        logic signed [31:0] key;
        t_status            status;
        logic [8:0]         count;
    } t_res;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    t_mode mode = MODE_PUSH;
    logic signed [31:0] key = '0;
    t_label label = '0;
    logic busy, done;
    logic [7:0] out_label;
    logic signed [31:0] out_key;
    t_status status;
    logic [8:0] count;

    indexed_min_heap_decrease_key_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_mode(mode), .i_key(key), .i_label(label), .o_done(done),
        .o_out_label(out_label), .o_out_key(out_key), .o_status(status),
        .o_count(count)
    );

    always #1 clk = ~clk;

    // shadow heap with position map
    logic signed [31:0] hk [HEAP_CAP];
    t_label             hl [HEAP_CAP];
    logic [8:0]         hpos [LABELS];
    logic               held [LABELS];
    int                 n_held;

    t_cmd cmd_queue[$];
    t_res heap_results[$];
    int errors = 0;
    int n_sent = 0, n_checked = 0, n_pops = 0, n_full = 0;
    int idle_cycles = 0;

    function automatic void swap_slots(int a, int b);
        logic signed [31:0] k;
        t_label l;
        k = hk[a]; l = hl[a];
        hk[a] = hk[b]; hl[a] = hl[b];
        hk[b] = k; hl[b] = l;
        hpos[hl[a]] = a[8:0];
        hpos[hl[b]] = b[8:0];
    endfunction

    function automatic void bubble_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!(hk[i] < hk[p])) break;
            swap_slots(p, i);
            i = p;
        end
    endfunction

    function automatic void bubble_down(int i);
        int l, r, c;
        forever begin
            l = 2 * i + 1;
            r = l + 1;
            if (l >= n_held) break;
            c = l;
            if (r < n_held && hk[r] < hk[l]) c = r;
            if (!(hk[c] < hk[i])) break;
            swap_slots(c, i);
            i = c;
        end
    endfunction

    function automatic t_res heap_apply(t_cmd c);
        t_res r;
        int s;
        logic signed [31:0] old;
        r = '0;
        case (c.mode)
            MODE_PUSH: begin
                if (held[c.label]) r.status = ST_DUP;
                else if (n_held >= HEAP_CAP) r.status = ST_FULL;
                else begin
                    s = n_held;
                    hk[s] = c.key; hl[s] = c.label;
                    hpos[c.label] = s[8:0]; held[c.label] = 1'b1;
                    n_held++;
                    bubble_up(s);
                end
            end
            MODE_POP: begin
                if (n_held == 0) r.status = ST_EMPTY;
                else begin
                    r.label = hl[0]; r.key = hk[0];
                    held[hl[0]] = 1'b0;
                    n_held--;
                    if (n_held > 0) begin
                        hk[0] = hk[n_held]; hl[0] = hl[n_held];
                        hpos[hl[0]] = '0;
                        bubble_down(0);
                    end
                end
            end
            MODE_CHANGE: begin
                if (!held[c.label]) r.status = ST_ABSENT;
                else begin
                    s = hpos[c.label];
                    old = hk[s];
                    hk[s] = c.key;
                    if (old < c.key) bubble_down(s);
                    else bubble_up(s);
                end
            end
            default: ;
        endcase
        r.count = n_held[8:0];
        return r;
    endfunction

    function automatic logic signed [31:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff - $urandom_range(0, 3);
            1: return 32'sh80000000 + $urandom_range(0, 3);
            2: return $signed($urandom_range(0, 20)) - 10;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic int gap_len();
        int g;
        g = $urandom_range(0, 99);
        if (g < 50) return 0;
        if (g < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stimulus: directed part then random phases
    initial begin
        t_cmd c;
        int phase;
        cmd_queue.push_back('{MODE_POP, 32'sd0, 8'd0});
        cmd_queue.push_back('{MODE_CHANGE, 32'sd5, 8'd9});
        cmd_queue.push_back('{MODE_PUSH, 32'sh7fffffff, 8'd255});
        cmd_queue.push_back('{MODE_PUSH, 32'sh80000000, 8'd0});
        cmd_queue.push_back('{MODE_PUSH, 32'sd0, 8'd170});
        cmd_queue.push_back('{MODE_PUSH, -32'sd1, 8'd85});
        cmd_queue.push_back('{MODE_PUSH, 32'sd3, 8'd255});
        cmd_queue.push_back('{MODE_CHANGE, 32'sh80000000, 8'd255});
        cmd_queue.push_back('{MODE_CHANGE, 32'sh7fffffff, 8'd0});
        cmd_queue.push_back('{MODE_CHANGE, 32'sd0, 8'd170});
        cmd_queue.push_back('{2'd3, 32'sh5a5a5a5a, 8'd7});
        for (int i = 0; i < 6; i++) cmd_queue.push_back('{MODE_POP, 32'sd0, 8'd0});
        // fill to capacity, push a held label into the full heap, change keys, then drain partly
        for (int i = 0; i < HEAP_CAP; i++) cmd_queue.push_back('{MODE_PUSH, rand_key(), i[7:0]});
        cmd_queue.push_back('{MODE_PUSH, 32'sd1, 8'd3});
        for (int i = 0; i < 40; i++) cmd_queue.push_back('{MODE_CHANGE, rand_key(),
            8'($urandom)});
        for (int i = 0; i < HEAP_CAP - 20; i++) cmd_queue.push_back('{MODE_POP, 32'sd0, 8'd0});
        // random phases, push-heavy or pop-heavy, mostly on a small label set
        for (int i = 0; i < 200; i++) begin
            phase = (i / 100) % 2;
            c.key = rand_key();
            c.label = (i % 3 == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
            case ($urandom_range(0, 99))
                0: c.mode = 2'd3;
                default: begin
                    int r;
                    r = $urandom_range(0, 98);
                    if (r < (phase ? 25 : 50)) c.mode = MODE_PUSH;
                    else if (r < 70) c.mode = MODE_POP;
                    else c.mode = MODE_CHANGE;
                end
            endcase
            cmd_queue.push_back(c);
        end
    end

    // reset
    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver: present a command, hold until the transfer, then idle for a gap
    int gap = 0;
    logic busy_at_edge = 1'b1;

    always @(negedge clk) begin
        t_cmd c;
        if (rst_n) begin
            if (!start || !busy_at_edge) begin
                if (gap > 0) begin
                    gap--;
                    start <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    c = cmd_queue.pop_front();
                    mode <= c.mode; key <= c.key; label <= c.label;
                    start <= 1'b1;
                    gap = gap_len();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: command transfers feed the predictor, results are checked
    always @(posedge clk) begin
        busy_at_edge <= rst_n ? busy : 1'b1;
        if (rst_n) begin
            idle_cycles++;
            if (start && !busy) begin
                t_res e;
                e = heap_apply('{mode, key, label});
                heap_results.push_back(e);
                n_sent++;
                if (mode == MODE_POP && e.status == ST_OK) n_pops++;
                if (e.status == ST_FULL) n_full++;
                idle_cycles = 0;
            end
            if (done) begin
                t_res got;
                idle_cycles = 0;
                got = '{out_label, out_key, status, count};
                if (heap_results.size() == 0) begin
                    $display("%0t unexpected result %h", $realtime, got);
                    errors++;
                end else begin
                    t_res e;
                    e = heap_results.pop_front();
                    n_checked++;
                    if (got.label !== e.label) begin
                        $display("%0t out_label exp %0d got %0d", $realtime, e.label, got.label);
                        errors++;
                    end
                    if (got.key !== e.key) begin
                        $display("%0t out_key exp %0d got %0d", $realtime, e.key, got.key);
                        errors++;
                    end
                    if (got.status !== e.status) begin
                        $display("%0t status exp %0d got %0d", $realtime, e.status, got.status);
                        errors++;
                    end
                    if (got.count !== e.count) begin
                        $display("%0t count exp %0d got %0d", $realtime, e.count, got.count);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
                $display("indexed_min_heap_decrease_key_core_test NOT OK");
                $finish;
            end
        end
    end

    // end of run
    initial begin
        for (int i = 0; i < HEAP_CAP; i++) held[i] = 1'b0;
        n_held = 0;
        wait (rst_n);
        wait (cmd_queue.size() == 0 && !start);
        wait (heap_results.size() == 0);
        repeat (60) @(posedge clk);
        $display("commands %0d, results checked %0d, pops %0d, full rejects %0d",
            n_sent, n_checked, n_pops, n_full);
        if (errors == 0 && heap_results.size() == 0) begin
            $display("indexed_min_heap_decrease_key_core_test OK");
        end else begin
            $display("indexed_min_heap_decrease_key_core_test NOT OK");
        end
        $finish;
    end

endmodule
